@@ sv/bcd_time_to_epoch_seconds_top_defines.svh @@
// assertion macros of the checker file of the bcd time converter
// needs nothing else; included by bare file name
`ifndef BCD_TIME_TO_EPOCH_SECONDS_TOP_DEFINES_SVH
`define BCD_TIME_TO_EPOCH_SECONDS_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bte check failed");

// next-cycle implication, disabled during reset
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bte check failed");

`endif

@@ sv/bte_pkg.sv @@
// types, constants and the month table of the bcd time to epoch seconds converter
// no dependencies
package bte_pkg;

    // one input beat: a bcd time message
    typedef struct packed {
        logic        mode;
        logic        leap_year;
        logic [7:0]  fraction_bcd;
        logic [6:0]  seconds_bcd;
        logic [6:0]  minutes_bcd;
        logic [5:0]  hours_bcd;
        logic [9:0]  day_bcd;
        logic [4:0]  month_bcd;
        logic [15:0] year_bcd;
    } in_t;

    // one output beat
    typedef struct packed {
        logic signed [38:0] epoch_seconds;
        logic [23:0]        fraction_100ns;
        logic               date_format;
        logic               day_error;
    } out_t;

    // decoded message, first pipeline stage
    typedef struct packed {
        logic        mode;
        logic        err;
        logic [23:0] frac;
        logic [17:0] tod;
        logic [10:0] doy_days;  // day count of the day-of-year form
        logic [14:0] yy;        // march-based year shifted by 400
        logic [8:0]  mdays;     // days into the march-based year
    } dec_t;

    localparam logic [0:0] MODE_DOY  = 1'b0;
    localparam logic [0:0] MODE_DATE = 1'b1;

    localparam int unsigned DAYS_TO_1971 = 365;
    localparam int unsigned DAYS_TO_1972 = 730;
    localparam int unsigned YEAR_SHIFT   = 400;
    // 146097 + 719468 + 1 (day of month counts from one)
    localparam int unsigned DAY_OFFSET   = 865566;
    localparam int unsigned SECS_PER_DAY = 86400;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 43690
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;

    // days from march 1st to the first of the month, month index 0 = january
    function automatic logic [8:0] month_doy(input logic [3:0] mon0);
        logic [8:0] d;
        unique case (mon0)
            4'd0:    d = 9'd306;
            4'd1:    d = 9'd337;
            4'd2:    d = 9'd0;
            4'd3:    d = 9'd31;
            4'd4:    d = 9'd61;
            4'd5:    d = 9'd92;
            4'd6:    d = 9'd122;
            4'd7:    d = 9'd153;
            4'd8:    d = 9'd184;
            4'd9:    d = 9'd214;
            4'd10:   d = 9'd245;
            4'd11:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ sv/bte_decode.sv @@
// digit decode of one bcd time message: time of day, fraction, day counts, year
// depends on bte_pkg
module bte_decode
    import bte_pkg::*;
(
    input  in_t  msg,
    output dec_t dec
);

    logic [6:0]  sec_v;
    logic [6:0]  min_v;
    logic [5:0]  hr_v;
    logic [8:0]  yday;
    logic [7:0]  mday;
    logic [5:0]  mraw;
    logic [1:0]  mq;
    logic [3:0]  mon0;
    logic [14:0] year_v;

    always_comb
    begin
        sec_v = 7'(msg.seconds_bcd[6:4]) * 7'd10 + 7'(msg.seconds_bcd[3:0]);
        min_v = 7'(msg.minutes_bcd[6:4]) * 7'd10 + 7'(msg.minutes_bcd[3:0]);
        hr_v  = 6'(msg.hours_bcd[5:4]) * 6'd10 + 6'(msg.hours_bcd[3:0]);

        yday = 9'(msg.day_bcd[9:8]) * 9'd100 + 9'(msg.day_bcd[7:4]) * 9'd10
             + 9'(msg.day_bcd[3:0]);
        mday = 8'(msg.day_bcd[7:4]) * 8'd10 + 8'(msg.day_bcd[3:0]);

        // month - 1 + 12, split into year carry and month index
        mraw = 6'(msg.month_bcd[4]) * 6'd10 + 6'(msg.month_bcd[3:0]) + 6'd11;
        priority if (mraw >= 6'd36) mq = 2'd3;
        else if (mraw >= 6'd24)     mq = 2'd2;
        else if (mraw >= 6'd12)     mq = 2'd1;
        else                        mq = 2'd0;
        mon0 = 4'(mraw - 6'(mq) * 6'd12);

        year_v = 15'(msg.year_bcd[15:12]) * 15'd1000 + 15'(msg.year_bcd[11:8]) * 15'd100
               + 15'(msg.year_bcd[7:4]) * 15'd10 + 15'(msg.year_bcd[3:0]);

        dec.mode = msg.mode;
        dec.err  = (msg.mode == MODE_DOY)
                && (yday > (msg.leap_year ? 9'd366 : 9'd365));
        dec.frac = 24'(msg.fraction_bcd[7:4]) * 24'd1000000
                 + 24'(msg.fraction_bcd[3:0]) * 24'd100000;
        dec.tod  = 18'(hr_v) * 18'd3600 + 18'(min_v) * 18'd60 + 18'(sec_v);
        dec.doy_days = (msg.leap_year ? 11'(DAYS_TO_1972) : 11'(DAYS_TO_1971))
                     + 11'(yday) - 11'd1;
        // january and february belong to the march-based year before
        dec.yy    = year_v + 15'(YEAR_SHIFT) + 15'(mq) - 15'd1 - 15'(mon0 < 4'd2);
        dec.mdays = month_doy(mon0) + 9'(mday);
    end

endmodule

@@ sv/bcd_time_to_epoch_seconds_top.sv @@
// registers: an accepted message beat passes s1_reg, s2_reg, s3_reg and s4_reg in order to its result beat
// throughput: one beat per cycle; bubbles collapse, each stage holds under back-pressure
// stages: digit decode, reciprocal divides by 100 and 400, day count, day*86400 + time of day
// reset: asynchronous, clears the stage valid bits only; data registers are not reset
// depends on bte_pkg and bte_decode
module bcd_time_to_epoch_seconds_top
    import bte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    output logic msg_ready,
    input  in_t  msg,
    output logic res_valid,
    input  logic res_ready,
    output out_t res
);

    // stage 2: leap-year terms of the day count
    typedef struct packed {
        logic        mode;
        logic        err;
        logic [23:0] frac;
        logic [17:0] tod;
        logic [10:0] doy_days;
        logic [23:0] yy365;
        logic [12:0] q4;
        logic [8:0]  q100;
        logic [6:0]  q400;
        logic [8:0]  mdays;
    } s2_t;

    // stage 3: signed day count since 1970-01-01
    typedef struct packed {
        logic               mode;
        logic               err;
        logic [23:0]        frac;
        logic [17:0]        tod;
        logic signed [24:0] days;
    } s3_t;

    dec_t dec;
    dec_t s1_reg;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    out_t s4_reg, s4_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [27:0]        p100;
    logic [25:0]        p400;
    logic [24:0]        day_pos;
    logic signed [42:0] secs_full;

    // digit decode sits in front of the first register
    bte_decode u_decode (
        .msg (msg),
        .dec (dec)
    );

    // a stage takes a new beat when it is empty or its content moves on
    assign rdy4 = !v4_reg || res_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign msg_ready = rdy1;
    assign res_valid = v4_reg;
    assign res       = s4_reg;

    // stage 2: year times 365, year / 4, and divisions by 100 and 400 through a reciprocal multiply
    always_comb
    begin
        p100 = 28'(s1_reg.yy) * 28'(RECIP_100);
        p400 = 26'(s1_reg.yy[14:2]) * 26'(RECIP_100);

        s2_next.mode     = s1_reg.mode;
        s2_next.err      = s1_reg.err;
        s2_next.frac     = s1_reg.frac;
        s2_next.tod      = s1_reg.tod;
        s2_next.doy_days = s1_reg.doy_days;
        s2_next.yy365    = 24'(s1_reg.yy) * 24'd365;
        s2_next.q4       = s1_reg.yy[14:2];
        s2_next.q100     = p100[27:RECIP_SHIFT];
        s2_next.q400     = p400[25:RECIP_SHIFT];
        s2_next.mdays    = s1_reg.mdays;
    end

    // stage 3: gregorian day count, or the day-of-year count
    always_comb
    begin
        day_pos = 25'(s2_reg.yy365) + 25'(s2_reg.q4) + 25'(s2_reg.q400)
                + 25'(s2_reg.mdays);

        s3_next.mode = s2_reg.mode;
        s3_next.err  = s2_reg.err;
        s3_next.frac = s2_reg.frac;
        s3_next.tod  = s2_reg.tod;
        if (s2_reg.mode == MODE_DATE)
        begin
            s3_next.days = signed'(day_pos - 25'(s2_reg.q100) - 25'(DAY_OFFSET));
        end
        else
        begin
            s3_next.days = signed'(25'(s2_reg.doy_days));
        end
    end

    // stage 4: seconds, wrapping to 39 bits; a day past the year gives zero
    always_comb
    begin
        secs_full = 43'(s3_reg.days) * 43'sd86400 + signed'(43'(s3_reg.tod));

        s4_next.epoch_seconds  = s3_reg.err ? '0 : secs_full[38:0];
        s4_next.fraction_100ns = s3_reg.frac;
        s4_next.date_format    = s3_reg.mode;
        s4_next.day_error      = s3_reg.err;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= msg_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // data registers load only with a valid beat
    always_ff @(posedge clk)
    begin
        if (rdy1 && msg_valid) s1_reg <= dec;
        if (rdy2 && v1_reg)    s2_reg <= s2_next;
        if (rdy3 && v2_reg)    s3_reg <= s3_next;
        if (rdy4 && v3_reg)    s4_reg <= s4_next;
    end

endmodule

@@ sv/bte_checker.sv @@
// port-level checks of the bcd time converter, bound to the top level
// depends on bte_pkg and bcd_time_to_epoch_seconds_top_defines.svh
`include "bcd_time_to_epoch_seconds_top_defines.svh"

module bte_checker
    import bte_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic msg_valid,
    input logic msg_ready,
    input in_t  msg,
    input logic res_valid,
    input logic res_ready,
    input out_t res
);

    // result beat holds while stalled
    `BTE_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res))
    // an empty output stage means the whole pipeline can take a beat
    `BTE_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !res_valid, msg_ready)
    // date form never flags a day error
    `BTE_ASSERT_NOW(a_date_no_err, clk, rst_n, res_valid && res.date_format, !res.day_error)
    // a day past the year reports zero seconds
    `BTE_ASSERT_NOW(a_err_zero, clk, rst_n, res_valid && res.day_error, res.epoch_seconds == '0)
    // fraction stays within two digits of at most fifteen
    `BTE_ASSERT_NOW(a_frac_range, clk, rst_n, res_valid, res.fraction_100ns <= 24'd16500000)

endmodule

bind bcd_time_to_epoch_seconds_top bte_checker u_bte_checker (.*);
